// File: hw/rtl/dwm_pkg.sv
// Shared types and constants of the dry/wet mixer.
package dwm_pkg;

    // Fixed field widths
    localparam int CH_W       = 3;
    localparam int GAIN_W     = 17;
    localparam int GAIN_Q24_W = 26;
    localparam int DELAY_W    = 10;
    localparam int RAMP_W     = 12;
    localparam int NCH_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Gain constants
    localparam logic [GAIN_W-1:0]            GAIN_ONE_Q16 = 17'd65536;
    localparam logic signed [GAIN_Q24_W-1:0] GAIN_ONE_Q24 = 26'sd16777216;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RESIDUAL_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_FRAMES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 2'd2;

    // Register reset values
    localparam logic [DELAY_W-1:0] RESIDUAL_DELAY_RST  = 10'd0;
    localparam logic [RAMP_W-1:0]  RAMP_FRAMES_RST     = 12'd441;
    localparam logic [NCH_W-1:0]   ACTIVE_CHANNELS_RST = 4'd2;

    // Request to the gain unit: advance one frame, sampling a new target
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] target;
    } gain_req_t;

    // Status of the gain unit
    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] frame_gain;
    } gain_stat_t;

    // Access strobes to the delay ring
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } ring_ctl_t;

endpackage

// File: hw/rtl/dwm_if.sv
// Valid/ready channel interfaces for the sample and result streams.
interface dwm_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic [dwm_pkg::CH_W-1:0]        channel;
    logic signed [SAMPLE_BITS-1:0]   dry_sample;
    logic signed [SAMPLE_BITS-1:0]   wet_sample;
    logic [dwm_pkg::GAIN_W-1:0]      target_mix;

    modport source (output valid, channel, dry_sample, wet_sample, target_mix, input ready);
    modport sink   (input valid, channel, dry_sample, wet_sample, target_mix, output ready);
endinterface

interface dwm_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   mixed_sample;
    logic [dwm_pkg::CH_W-1:0]        channel_out;

    modport source (output valid, mixed_sample, channel_out, input ready);
    modport sink   (input valid, mixed_sample, channel_out, output ready);
endinterface

// File: hw/rtl/dwm_ring.sv
// Dry delay ring memory with a clearing pass after reset.
module dwm_ring #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dwm_pkg::ring_ctl_t  ctl,
    input  logic [ADDR_W-1:0]   rd_addr,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  logic [DATA_W-1:0]   wr_data,
    output logic [DATA_W-1:0]   rd_data,
    output logic                clearing
);
    import dwm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;
    localparam logic [ADDR_W-1:0] ADDR_LAST = {ADDR_W{1'b1}};

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clearing_reg;

    // Sweep every entry to silence after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_LAST)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Write port: clearing pass takes priority
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// File: hw/rtl/dwm_gain.sv
// Mix gain ramp: target tracking, bit-serial step division and frame advance.
module dwm_gain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dwm_pkg::RAMP_W-1:0]  ramp_frames,
    input  dwm_pkg::gain_req_t          req,
    output dwm_pkg::gain_stat_t         stat
);
    import dwm_pkg::*;

    localparam int MAG_W = GAIN_Q24_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(MAG_W);
    localparam logic signed [GAIN_Q24_W:0] ROUND_HALF = 27'sd128;
    localparam logic signed [GAIN_W+1:0]   GAIN_MAX_S = 19'sd65536;

    typedef enum logic [2:0] {G_IDLE, G_DIV, G_SIGN, G_ADV, G_FRAME} gstate_t;

    gstate_t                        state_reg;
    logic signed [GAIN_Q24_W-1:0]   current_reg;
    logic signed [GAIN_Q24_W-1:0]   step_reg;
    logic [GAIN_W-1:0]              target_reg;
    logic [RAMP_W-1:0]              countdown_reg;
    logic [GAIN_W-1:0]              frame_gain_reg;
    logic                           done_reg;
    logic [MAG_W-1:0]               quo_reg;
    logic [RAMP_W-1:0]              rem_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           neg_reg;

    logic [GAIN_W-1:0]              tgt_clamp;
    logic signed [GAIN_Q24_W-1:0]   tgt_q24;
    logic signed [GAIN_Q24_W-1:0]   target_q24;
    logic signed [GAIN_Q24_W-1:0]   num;
    logic signed [GAIN_Q24_W-1:0]   num_abs;
    logic [RAMP_W:0]                trial;
    logic [RAMP_W:0]                trial_sub;
    logic                           trial_ge;
    logic signed [GAIN_Q24_W-1:0]   quo_s;
    logic signed [GAIN_Q24_W:0]     rounded;
    logic signed [GAIN_W+1:0]       g_wide;
    logic [GAIN_W-1:0]              g_clamp;

    // Clamp the requested target and form the ramp numerator
    always_comb
    begin
        tgt_clamp  = (req.target > GAIN_ONE_Q16) ? GAIN_ONE_Q16 : req.target;
        tgt_q24    = $signed({1'b0, tgt_clamp, 8'd0});
        target_q24 = $signed({1'b0, target_reg, 8'd0});
        num        = tgt_q24 - current_reg;
        num_abs    = num[GAIN_Q24_W-1] ? -num : num;
    end

    // One restoring division step per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        trial_ge  = (trial >= {1'b0, ramp_frames});
        trial_sub = trial - {1'b0, ramp_frames};
        quo_s     = $signed({1'b0, quo_reg});
    end

    // Round the Q1.24 gain to Q16 and clamp to the unit range
    always_comb
    begin
        rounded = {current_reg[GAIN_Q24_W-1], current_reg} + ROUND_HALF;
        g_wide  = rounded[GAIN_Q24_W:8];
        priority if (g_wide[GAIN_W+1])
        begin
            g_clamp = '0;
        end
        else if (g_wide > GAIN_MAX_S)
        begin
            g_clamp = GAIN_ONE_Q16;
        end
        else
        begin
            g_clamp = g_wide[GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= G_IDLE;
            current_reg    <= GAIN_ONE_Q24;
            step_reg       <= '0;
            target_reg     <= GAIN_ONE_Q16;
            countdown_reg  <= '0;
            frame_gain_reg <= GAIN_ONE_Q16;
            done_reg       <= 1'b0;
            quo_reg        <= '0;
            rem_reg        <= '0;
            cnt_reg        <= '0;
            neg_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                G_IDLE:
                begin
                    if (req.start)
                    begin
                        if (tgt_clamp == target_reg)
                        begin
                            // Same target: keep the ramp running
                            state_reg <= G_ADV;
                        end
                        else if (ramp_frames == '0)
                        begin
                            // Jump straight to the new target
                            target_reg    <= tgt_clamp;
                            current_reg   <= tgt_q24;
                            step_reg      <= '0;
                            countdown_reg <= '0;
                            state_reg     <= G_ADV;
                        end
                        else
                        begin
                            // Start a new ramp: divide the distance by its length
                            target_reg    <= tgt_clamp;
                            countdown_reg <= ramp_frames;
                            neg_reg       <= num[GAIN_Q24_W-1];
                            quo_reg       <= num_abs[MAG_W-1:0];
                            rem_reg       <= '0;
                            cnt_reg       <= DIV_STEPS;
                            state_reg     <= G_DIV;
                        end
                    end
                end
                G_DIV:
                begin
                    rem_reg <= trial_ge ? trial_sub[RAMP_W-1:0] : trial[RAMP_W-1:0];
                    quo_reg <= {quo_reg[MAG_W-2:0], trial_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_reg <= G_SIGN;
                    end
                end
                G_SIGN:
                begin
                    // Truncate toward zero: apply the sign to the magnitude quotient
                    step_reg  <= neg_reg ? -quo_s : quo_s;
                    state_reg <= G_ADV;
                end
                G_ADV:
                begin
                    if (countdown_reg != '0)
                    begin
                        countdown_reg <= countdown_reg - 1'b1;
                        if (countdown_reg != RAMP_W'(1))
                        begin
                            current_reg <= current_reg + step_reg;
                        end
                        else
                        begin
                            current_reg <= target_q24;
                        end
                    end
                    state_reg <= G_FRAME;
                end
                G_FRAME:
                begin
                    frame_gain_reg <= g_clamp;
                    done_reg       <= 1'b1;
                    state_reg      <= G_IDLE;
                end
                default:
                begin
                    state_reg <= G_IDLE;
                end
            endcase
        end
    end

    assign stat.done       = done_reg;
    assign stat.frame_gain = frame_gain_reg;

endmodule

// File: hw/rtl/dry_wet_mix_with_dry_delay.sv
// Dry/wet crossfade mixer with per-channel dry delay: top level.
//
// Usage: one channel sample per transaction on "items" (channel, dry, wet,
// target mix); one mixed sample per transaction on "results", echoing the
// channel. Channels of a frame arrive in order, channel 0 first. The three
// registers are written through cfg_we/cfg_index/cfg_data, by the user only
// while idle; the block does not enforce it. Items are processed one at a
// time: a nonzero channel passes S_RING, S_MUL_WET, S_MUL_DRY, S_SUM and
// S_OUT before its result is loaded, and no new item is taken until then.
// Channel 0 first advances the gain ramp; when the target changes with a
// nonzero ramp length, a bit-serial divider first computes the per-frame
// gain step (one quotient bit a cycle). The dry delay ring is one memory
// with one write and one registered read port, row per channel and column
// per frame position. After reset the ring is cleared to silence, one entry
// a cycle; no item is taken meanwhile.
// Results sit in an output register; while the receiver stalls, the next
// item is still accepted and processed, then held until the register frees.
module dry_wet_mix_with_dry_delay #(
    parameter int MAX_CHANNELS = 8,
    parameter int DELAY_DEPTH  = 1024,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dwm_in_if.sink                            items,
    dwm_out_if.source                         results,
    input  logic                              cfg_we,
    input  logic [dwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dwm_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dwm_pkg::*;

    localparam int ADDR_W  = $clog2(DELAY_DEPTH);
    localparam int ROW_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int RING_AW = ROW_W + ADDR_W;
    localparam int P_W     = SAMPLE_BITS + GAIN_W + 1;
    localparam int Q_W     = P_W + 1 - 16;
    localparam logic [ADDR_W-1:0] POS_LAST   = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_W1   = (ADDR_W + 1)'(DELAY_DEPTH);
    localparam logic [NCH_W-1:0]  NCH_MAX    = NCH_W'(MAX_CHANNELS);
    localparam logic signed [P_W:0] ROUND_HALF = (P_W + 1)'(32768);
    localparam logic signed [Q_W-1:0] SAT_MAX =
        {{(Q_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] SAT_MIN =
        {{(Q_W - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE, S_GAIN, S_RING, S_MUL_WET, S_MUL_DRY, S_SUM, S_OUT
    } state_t;

    // Fold a channel index onto a ring row
    function automatic logic [ROW_W-1:0] chan_row(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] r;
        r = ch;
        for (int i = 0; i < (1 << CH_W); i++)
        begin
            if (32'(r) >= MAX_CHANNELS)
            begin
                r = r - CH_W'(MAX_CHANNELS);
            end
        end
        return ROW_W'(r);
    endfunction

    // Configuration registers
    logic [DELAY_W-1:0] residual_delay_reg;
    logic [RAMP_W-1:0]  ramp_frames_reg;
    logic [NCH_W-1:0]   active_channels_reg;

    // Control and datapath registers
    state_t                         state_reg;
    logic [ADDR_W-1:0]              wp_reg;
    logic [CH_W-1:0]                ch_reg;
    logic signed [SAMPLE_BITS-1:0]  dry_reg;
    logic signed [SAMPLE_BITS-1:0]  wet_reg;
    logic signed [P_W-1:0]          prod_wet_reg;
    logic signed [P_W-1:0]          prod_dry_reg;
    logic signed [SAMPLE_BITS-1:0]  mix_reg;
    logic signed [SAMPLE_BITS-1:0]  mixed_reg;
    logic [CH_W-1:0]                chan_out_reg;
    logic                           out_valid_reg;

    gain_req_t                      gain_req;
    gain_stat_t                     gain_stat;
    ring_ctl_t                      ring_ctl;
    logic [RING_AW-1:0]             ring_rd_addr;
    logic [RING_AW-1:0]             ring_wr_addr;
    logic [SAMPLE_BITS-1:0]         ring_rd_data;
    logic                           ring_clearing;

    logic                           accept;
    logic                           out_load;
    logic [ADDR_W-1:0]              dly;
    logic                           dly_on;
    logic [ADDR_W:0]                rp_wide;
    logic [ADDR_W-1:0]              rp;
    logic [ROW_W-1:0]               row;
    logic [NCH_W-1:0]               nch;
    logic                           is_last;
    logic signed [GAIN_W:0]         wet_gain_s;
    logic [GAIN_W-1:0]              dry_gain;
    logic signed [GAIN_W:0]         dry_gain_s;
    logic signed [P_W-1:0]          prod_wet;
    logic signed [P_W-1:0]          prod_dry;
    logic signed [P_W:0]            sum;
    logic signed [Q_W-1:0]          quot;
    logic signed [SAMPLE_BITS-1:0]  sat;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            residual_delay_reg  <= RESIDUAL_DELAY_RST;
            ramp_frames_reg     <= RAMP_FRAMES_RST;
            active_channels_reg <= ACTIVE_CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RESIDUAL_DELAY:  residual_delay_reg  <= cfg_data[DELAY_W-1:0];
                CFG_RAMP_FRAMES:     ramp_frames_reg     <= cfg_data[RAMP_W-1:0];
                CFG_ACTIVE_CHANNELS: active_channels_reg <= cfg_data[NCH_W-1:0];
                default:             ;
            endcase
        end
    end

    // Clamp delay and channel count, form ring positions
    always_comb
    begin
        if (32'(residual_delay_reg) > DELAY_DEPTH - 1)
        begin
            dly = POS_LAST;
        end
        else
        begin
            dly = ADDR_W'(residual_delay_reg);
        end
        dly_on = (dly != '0);
        if (wp_reg < dly)
        begin
            rp_wide = {1'b0, wp_reg} + DEPTH_W1 - {1'b0, dly};
        end
        else
        begin
            rp_wide = {1'b0, wp_reg} - {1'b0, dly};
        end
        rp  = rp_wide[ADDR_W-1:0];
        row = chan_row(ch_reg);
        priority if (active_channels_reg == '0)
        begin
            nch = NCH_W'(1);
        end
        else if (active_channels_reg > NCH_MAX)
        begin
            nch = NCH_MAX;
        end
        else
        begin
            nch = active_channels_reg;
        end
        is_last = ({1'b0, ch_reg} == (nch - 1'b1));
    end

    // Mix arithmetic: wet and dry products, each registered in its own state, then round and saturate
    always_comb
    begin
        wet_gain_s = $signed({1'b0, gain_stat.frame_gain});
        dry_gain   = GAIN_ONE_Q16 - gain_stat.frame_gain;
        dry_gain_s = $signed({1'b0, dry_gain});
        prod_wet   = wet_reg * wet_gain_s;
        prod_dry   = dry_reg * dry_gain_s;
        sum        = {prod_wet_reg[P_W-1], prod_wet_reg}
                   + {prod_dry_reg[P_W-1], prod_dry_reg} + ROUND_HALF;
        quot       = sum[P_W:16];
        priority if (quot > SAT_MAX)
        begin
            sat = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (quot < SAT_MIN)
        begin
            sat = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = quot[SAMPLE_BITS-1:0];
        end
    end

    // Handshake and unit requests
    assign items.ready     = (state_reg == S_IDLE) && !ring_clearing;
    assign accept          = items.valid && items.ready;
    assign gain_req.start  = accept && (items.channel == '0);
    assign gain_req.target = items.target_mix;
    assign out_load        = (state_reg == S_OUT) && (!out_valid_reg || results.ready);

    // Write the new dry sample and read the delayed one in the same cycle
    assign ring_ctl.wr_en = (state_reg == S_RING) && dly_on;
    assign ring_ctl.rd_en = (state_reg == S_RING) && dly_on;
    assign ring_rd_addr   = {row, rp};
    assign ring_wr_addr   = {row, wp_reg};

    dwm_gain u_gain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ramp_frames (ramp_frames_reg),
        .req         (gain_req),
        .stat        (gain_stat)
    );

    dwm_ring #(
        .ADDR_W (RING_AW),
        .DATA_W (SAMPLE_BITS)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ring_ctl),
        .rd_addr  (ring_rd_addr),
        .wr_addr  (ring_wr_addr),
        .wr_data  (dry_reg),
        .rd_data  (ring_rd_data),
        .clearing (ring_clearing)
    );

    // Sequencer: state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            ch_reg        <= '0;
            dry_reg       <= '0;
            wet_reg       <= '0;
            prod_wet_reg  <= '0;
            prod_dry_reg  <= '0;
            mix_reg       <= '0;
            mixed_reg     <= '0;
            chan_out_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Load a finished result, or drop the held one once the receiver takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ch_reg    <= items.channel;
                        dry_reg   <= items.dry_sample;
                        wet_reg   <= items.wet_sample;
                        state_reg <= (items.channel == '0) ? S_GAIN : S_RING;
                    end
                end
                S_GAIN:
                begin
                    if (gain_stat.done)
                    begin
                        state_reg <= S_RING;
                    end
                end
                S_RING:
                begin
                    // Advance the write position after the last channel of a frame
                    if (dly_on && is_last)
                    begin
                        wp_reg <= (wp_reg == POS_LAST) ? '0 : wp_reg + 1'b1;
                    end
                    state_reg <= S_MUL_WET;
                end
                S_MUL_WET:
                begin
                    if (dly_on)
                    begin
                        dry_reg <= ring_rd_data;
                    end
                    prod_wet_reg <= prod_wet;
                    state_reg    <= S_MUL_DRY;
                end
                S_MUL_DRY:
                begin
                    prod_dry_reg <= prod_dry;
                    state_reg    <= S_SUM;
                end
                S_SUM:
                begin
                    mix_reg   <= sat;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold while the previous result still waits
                    if (out_load)
                    begin
                        mixed_reg    <= mix_reg;
                        chan_out_reg <= ch_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.mixed_sample = mixed_reg;
    assign results.channel_out  = chan_out_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ring_clearing |-> !items.ready)
        else $error("item accepted during ring clearing pass");

    a_ring_distinct_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_ctl.rd_en && ring_ctl.wr_en) |-> (ring_rd_addr != ring_wr_addr))
        else $error("ring read and write hit the same entry");

    a_one_item_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready) |=> !items.ready)
        else $error("second item accepted while one is in process");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");
`endif

endmodule

// File: tb/sv/tb_dry_wet_mix_with_dry_delay.sv
// Self-checking testbench of the dry/wet crossfade mixer with per-channel dry delay.
`timescale 1ns / 1ps

module tb_dry_wet_mix_with_dry_delay;
    import dwm_pkg::*;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_CH        = 8;
    localparam int RING_DEPTH    = 1024;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 11;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 200;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [CH_W-1:0]               channel;
        logic signed [SAMPLE_BITS-1:0] dry;
        logic signed [SAMPLE_BITS-1:0] wet;
        logic [GAIN_W-1:0]             target;
    } sample_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mixed;
        logic [CH_W-1:0]               channel;
    } mix_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dwm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) items_ch ();
    dwm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) results_ch ();

    dry_wet_mix_with_dry_delay #(
        .MAX_CHANNELS (MAX_CH),
        .DELAY_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mixer state mirrored by the predictor
    logic signed [SAMPLE_BITS-1:0] dry_line [MAX_CH][RING_DEPTH];
    int unsigned line_pos       = 0;
    longint      gain_q24       = GAIN_ONE_Q24;
    longint      gain_inc       = 0;
    int unsigned gain_target    = GAIN_ONE_Q16;
    int unsigned ramp_left      = 0;
    int unsigned frame_gain_q16 = GAIN_ONE_Q16;
    int unsigned reg_delay      = RESIDUAL_DELAY_RST;
    int unsigned reg_ramp       = RAMP_FRAMES_RST;
    int unsigned reg_nch        = ACTIVE_CHANNELS_RST;

    mix_t        mix_expected_q[$];
    mix_t        mix_want;
    int unsigned err_count    = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    bit          hold_req     = 1'b0;
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    logic [GAIN_W-1:0] held_target = GAIN_ONE_Q16;

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_dry_wet_mix_with_dry_delay NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MAX_REPORTS)
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // Compute the mixed sample of one transaction and advance the mirrored state
    function automatic mix_t predict_mix(input sample_t s);
        int unsigned nch;
        int unsigned dly;
        int unsigned tgt;
        int unsigned wp;
        int unsigned rp;
        longint      dry;
        longint      wet;
        longint      acc;
        longint      g;
        mix_t        r;

        nch = (reg_nch == 0) ? 1 : ((reg_nch > MAX_CH) ? MAX_CH : reg_nch);
        dly = (reg_delay > RING_DEPTH - 1) ? RING_DEPTH - 1 : reg_delay;
        dry = s.dry;
        wet = s.wet;

        // Sample the target and step the gain ramp once per frame
        if (s.channel == 0) begin
            tgt = (s.target > GAIN_ONE_Q16) ? GAIN_ONE_Q16 : s.target;
            if (tgt != gain_target) begin
                gain_target = tgt;
                if (reg_ramp == 0) begin
                    gain_q24  = longint'(tgt) * 256;
                    gain_inc  = 0;
                    ramp_left = 0;
                end
                else begin
                    ramp_left = reg_ramp;
                    gain_inc  = (longint'(tgt) * 256 - gain_q24) / longint'(reg_ramp);
                end
            end
            if (ramp_left != 0) begin
                ramp_left--;
                if (ramp_left != 0)
                    gain_q24 += gain_inc;
                else
                    gain_q24 = longint'(gain_target) * 256;
            end
            g = (gain_q24 + 128) / 256;
            if (g < 0)
                g = 0;
            if (g > longint'(GAIN_ONE_Q16))
                g = GAIN_ONE_Q16;
            frame_gain_q16 = 32'(g);
        end

        // Push the dry sample through its channel's ring
        if (dly != 0) begin
            wp = line_pos % RING_DEPTH;
            rp = (wp + RING_DEPTH - dly) % RING_DEPTH;
            dry_line[s.channel][wp] = s.dry;
            dry = dry_line[s.channel][rp];
            if (s.channel == nch - 1)
                line_pos = (wp + 1) % RING_DEPTH;
        end

        // Blend, round half up, saturate
        acc = wet * longint'(frame_gain_q16)
            + dry * (longint'(GAIN_ONE_Q16) - longint'(frame_gain_q16));
        acc = (acc + 32768) >>> 16;
        if (acc > longint'(SAMPLE_MAX))
            acc = SAMPLE_MAX;
        if (acc < longint'(SAMPLE_MIN))
            acc = SAMPLE_MIN;
        r.mixed   = acc[SAMPLE_BITS-1:0];
        r.channel = s.channel;
        return r;
    endfunction

    function automatic sample_t mk_sample(input int unsigned ch, input longint dry,
                                          input longint wet, input int unsigned tgt);
        sample_t s;
        s.channel = CH_W'(ch);
        s.dry     = SAMPLE_BITS'(dry);
        s.wet     = SAMPLE_BITS'(wet);
        s.target  = GAIN_W'(tgt);
        return s;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return '0;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_target();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return GAIN_ONE_Q16;
            2:       return GAIN_W'($urandom_range(GAIN_ONE_Q16 + 1, 2**GAIN_W - 1));
            default: return GAIN_W'($urandom_range(0, GAIN_ONE_Q16));
        endcase
    endfunction

    // Write one register; caller guarantees the mixer is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_RESIDUAL_DELAY:  reg_delay = val[DELAY_W-1:0];
            CFG_RAMP_FRAMES:     reg_ramp  = val[RAMP_W-1:0];
            CFG_ACTIVE_CHANNELS: reg_nch   = val[NCH_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one transaction and record its expected mix once accepted
    task automatic send_sample(input sample_t s);
        while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT)
            @(negedge clk);
        items_ch.channel    = s.channel;
        items_ch.dry_sample = s.dry;
        items_ch.wet_sample = s.wet;
        items_ch.target_mix = s.target;
        items_ch.valid      = 1'b1;
        do
            @(posedge clk);
        while (!items_ch.ready);
        mix_expected_q.push_back(predict_mix(s));
        @(negedge clk);
        items_ch.valid = 1'b0;
    endtask

    // Hold until every expected mix has come back, then let the pipeline settle
    task automatic wait_all_mixed();
        while (mix_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mostly well-formed frames with random content, some stray transactions
    task automatic send_frames(input int unsigned n_items);
        int unsigned nch;
        int unsigned sent;

        nch  = (reg_nch == 0) ? 1 : ((reg_nch > MAX_CH) ? MAX_CH : reg_nch);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_sample(mk_sample($urandom_range(0, MAX_CH - 1), rand_sample(),
                                      rand_sample(), $urandom_range(0, 2**GAIN_W - 1)));
                sent++;
            end
            else begin
                if ($urandom_range(0, 5) == 0)
                    held_target = rand_target();
                for (int unsigned c = 0; c < nch; c++) begin
                    send_sample(mk_sample(c, rand_sample(), rand_sample(),
                                          (c == 0) ? held_target
                                                   : $urandom_range(0, 2**GAIN_W - 1)));
                    sent++;
                end
            end
        end
    endtask

    // Default settings: fully wet, targets on other channels ignored
    task automatic test_wet_passthrough();
        send_sample(mk_sample(0, SAMPLE_MAX, SAMPLE_MIN, GAIN_ONE_Q16));
        send_sample(mk_sample(1, SAMPLE_MIN, SAMPLE_MAX, 0));
        send_sample(mk_sample(0, 0, -1, GAIN_ONE_Q16));
        send_sample(mk_sample(1, 1, 0, 2**GAIN_W - 1));
        wait_all_mixed();
    endtask

    // Zero ramp length: jump to target, clamp above range, rounding of halves
    task automatic test_instant_targets();
        write_reg(CFG_RAMP_FRAMES, 0);
        send_sample(mk_sample(0, SAMPLE_MAX, SAMPLE_MIN, 0));
        send_sample(mk_sample(1, SAMPLE_MIN, SAMPLE_MAX, GAIN_ONE_Q16));
        send_sample(mk_sample(0, 1, 0, 32768));
        send_sample(mk_sample(0, -1, 0, 32768));
        send_sample(mk_sample(0, SAMPLE_MAX, 5, 2**GAIN_W - 1));
        send_sample(mk_sample(0, -3, 7, 0));
        wait_all_mixed();
    endtask

    // Dry delay: short ring, longest ring, channel counts out of range, stray channel
    task automatic test_dry_delay();
        write_reg(CFG_RESIDUAL_DELAY, 2);
        write_reg(CFG_ACTIVE_CHANNELS, 0);
        send_sample(mk_sample(0, 100, 0, 0));
        send_sample(mk_sample(0, 200, 0, 0));
        send_sample(mk_sample(0, 300, 0, 0));
        wait_all_mixed();
        write_reg(CFG_ACTIVE_CHANNELS, 15);
        write_reg(CFG_RESIDUAL_DELAY, 12'hFFF);
        send_sample(mk_sample(7, SAMPLE_MAX, 0, 0));
        send_sample(mk_sample(0, SAMPLE_MIN, 0, 0));
        wait_all_mixed();
        write_reg(CFG_ACTIVE_CHANNELS, 3);
        write_reg(CFG_RESIDUAL_DELAY, 1);
        send_sample(mk_sample(0, 11, 0, 0));
        send_sample(mk_sample(5, 22, 0, 0));
        send_sample(mk_sample(2, 33, 0, 0));
        send_sample(mk_sample(0, 44, 0, 0));
        wait_all_mixed();
    endtask

    // Ramps: one-frame landing, longest ramp, unchanged target, retarget mid-ramp
    task automatic test_ramp_landing();
        write_reg(CFG_RESIDUAL_DELAY, 0);
        write_reg(CFG_ACTIVE_CHANNELS, 1);
        write_reg(CFG_RAMP_FRAMES, 1);
        send_sample(mk_sample(0, SAMPLE_MAX, SAMPLE_MIN, GAIN_ONE_Q16));
        wait_all_mixed();
        write_reg(CFG_RAMP_FRAMES, 12'hFFF);
        send_sample(mk_sample(0, SAMPLE_MAX, SAMPLE_MIN, 0));
        send_sample(mk_sample(0, SAMPLE_MAX, SAMPLE_MIN, 0));
        send_sample(mk_sample(0, SAMPLE_MAX, SAMPLE_MIN, 20000));
        wait_all_mixed();
    endtask

    // Random frames under a series of register settings
    task automatic test_random_phases();
        int unsigned delays[8] = '{0, 1, 12'hFFF, 7, 300, 1023, 2, 0};
        int unsigned ramps[8]  = '{0, 1, 4095, 16, 3, 64, 8, 0};
        int unsigned nchs[8]   = '{2, 1, 8, 4, 0, 9, 15, 3};

        delays[7] = $urandom_range(0, 2**CFG_DATA_W - 1);
        ramps[7]  = $urandom_range(0, 2**CFG_DATA_W - 1);
        nchs[7]   = $urandom_range(0, 2**NCH_W - 1);
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_RESIDUAL_DELAY, CFG_DATA_W'(delays[p]));
            write_reg(CFG_RAMP_FRAMES, CFG_DATA_W'(ramps[p]));
            write_reg(CFG_ACTIVE_CHANNELS, CFG_DATA_W'(nchs[p]));
            // one phase runs flat out on both sides
            src_idle_en  = (p != 3);
            sink_idle_en = (p != 3);
            send_frames(PHASE_ITEMS);
            wait_all_mixed();
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // Long receiver hold-off while items keep coming, then a full pause
    task automatic test_output_backpressure();
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        src_idle_en = 1'b0;
        send_frames(40);
        src_idle_en = 1'b1;
        wait_all_mixed();
        send_frames(10);
        wait_all_mixed();
    endtask

    // Receiver: random idling, plus a hold-off on request
    initial begin
        results_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                results_ch.ready = 1'b0;
                hold_left--;
            end
            else begin
                results_ch.ready = !(sink_idle_en && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Compare each result transaction with the oldest expected mix
    always @(posedge clk) begin
        if (results_ch.valid && results_ch.ready) begin
            if (mix_expected_q.size() == 0) begin
                report_mismatch("result with nothing pending", results_ch.mixed_sample, 0);
            end
            else begin
                mix_want = mix_expected_q.pop_front();
                if (results_ch.channel_out !== mix_want.channel)
                    report_mismatch("channel_out", results_ch.channel_out, mix_want.channel);
                if (results_ch.mixed_sample !== mix_want.mixed)
                    report_mismatch("mixed_sample", results_ch.mixed_sample, mix_want.mixed);
            end
        end
    end

    initial begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_RESIDUAL_DELAY;
        cfg_data            = '0;
        items_ch.valid      = 1'b0;
        items_ch.channel    = '0;
        items_ch.dry_sample = '0;
        items_ch.wet_sample = '0;
        items_ch.target_mix = '0;
        foreach (dry_line[c, p])
            dry_line[c][p] = '0;

        // Hold reset, release on a falling edge
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_wet_passthrough();
        test_instant_targets();
        test_dry_delay();
        test_ramp_landing();
        test_random_phases();
        test_output_backpressure();
        wait_all_mixed();

        if (err_count == 0)
            $display("tb_dry_wet_mix_with_dry_delay OK");
        else
            $display("tb_dry_wet_mix_with_dry_delay NOT OK");
        $finish;
    end

endmodule
